>>> src/rfbr_pkg.sv
// shared types and constants of the rgb fade and brightness renderer
package rfbr_pkg;

  typedef logic [7:0] level_t;

  typedef enum logic [1:0] {
    CMD_SET_GOAL = 2'd0,
    CMD_RENDER   = 2'd1,
    CMD_FORCE    = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_AUTO   = 3'd0,
    MODE_MANUAL = 3'd1,
    MODE_DIST   = 3'd2,
    MODE_HYBRID = 3'd3,
    MODE_FULL   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    REG_FADE_ON  = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_MODE     = 2'd2
  } reg_e;

  localparam level_t NEAR_LIMIT = 8'd50;
  localparam level_t FAR_LIMIT  = 8'd100;
  localparam level_t FULL_LEVEL = 8'd255;

  localparam logic        FADE_ON_RST  = 1'b1;
  localparam logic [15:0] INTERVAL_RST = 16'd20;
  localparam logic [2:0]  MODE_RST     = 3'd0;

  // per-lane controls issued by the top level each cycle
  typedef struct packed {
    logic load_goal;
    logic do_step;
    logic do_jump;
    logic ld_s1;
    logic ld_s2;
  } lane_ctrl_t;

endpackage

>>> src/rfbr_if.sv
// valid/ready channel interfaces for items and results
interface rfbr_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  logic [31:0] now_ms;
  logic [7:0]  distance_brightness;
  logic [7:0]  ambient_brightness;

  modport source (
    output valid, cmd, red_in, green_in, blue_in, now_ms,
           distance_brightness, ambient_brightness,
    input  ready
  );
  modport sink (
    input  valid, cmd, red_in, green_in, blue_in, now_ms,
           distance_brightness, ambient_brightness,
    output ready
  );
endinterface

interface rfbr_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] pwm_red;
  logic [7:0] pwm_green;
  logic [7:0] pwm_blue;

  modport source (output valid, pwm_red, pwm_green, pwm_blue, input ready);
  modport sink (input valid, pwm_red, pwm_green, pwm_blue, output ready);
endinterface

>>> src/rfbr_lane.sv
// one colour channel: fade step, shown/goal state and brightness scaling
module rfbr_lane (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rfbr_pkg::lane_ctrl_t   ctrl_i,
  input  rfbr_pkg::level_t       goal_i,
  input  rfbr_pkg::level_t       bright_i,
  output rfbr_pkg::level_t       pwm_o
);
  import rfbr_pkg::*;

  level_t      shown_q, shown_d, goal_q;
  level_t      diff, step, stepped;
  level_t      s1_lvl_q;
  logic [15:0] prod_q, quot_sum;

  always_comb begin
    diff = (goal_q > shown_q) ? goal_q - shown_q : shown_q - goal_q;
    step = 8'd1;
    if (diff > NEAR_LIMIT) step = 8'd2;
    if (diff > FAR_LIMIT) step = 8'd4;
    // clamp at the goal, also covers a channel already there
    if (step > diff) step = diff;
    stepped = (goal_q > shown_q) ? shown_q + step : shown_q - step;

    shown_d = shown_q;
    if (ctrl_i.do_jump) begin
      shown_d = goal_q;
    end else if (ctrl_i.do_step) begin
      shown_d = stepped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q <= '0;
      goal_q  <= '0;
    end else begin
      shown_q <= shown_d;
      if (ctrl_i.load_goal) goal_q <= goal_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld_s1) s1_lvl_q <= shown_d;
    if (ctrl_i.ld_s2) prod_q <= {8'd0, s1_lvl_q} * {8'd0, bright_i};
  end

  // divide by 255 with rounding down: (p + (p >> 8) + 1) >> 8, exact for p <= 255*255
  assign quot_sum = prod_q + {8'd0, prod_q[15:8]} + 16'd1;
  assign pwm_o    = quot_sum[15:8];

endmodule

>>> src/rfbr_merge.sv
// output register that gathers the three lane levels into one result transfer
module rfbr_merge (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s2_valid_i,
  input  rfbr_pkg::level_t [2:0]  lvl_i,
  output logic                    free_o,
  rfbr_result_if.source           result_o
);
  import rfbr_pkg::*;

  logic   out_valid_q;
  level_t red_q, green_q, blue_q;

  assign free_o = !out_valid_q || result_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (free_o) begin
      out_valid_q <= s2_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o) begin
      red_q   <= lvl_i[0];
      green_q <= lvl_i[1];
      blue_q  <= lvl_i[2];
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.pwm_red   = red_q;
  assign result_o.pwm_green = green_q;
  assign result_o.pwm_blue  = blue_q;

endmodule

>>> src/rgb_fade_brightness_renderer.sv
// top level: config registers, fade timing, lane control and result pipeline
// a render or force result passes the s1 level, product and output registers in turn
// throughput: one item per cycle while the output is not stalled; the shown colour
// updates in the transfer cycle, then multiply and divide-by-255 run in two registered stages per lane
// a stalled output backs up through the stages; set-target items give no result
// reset (rst_ni low, asynchronous): colours and last step time zero, fade on,
// interval 20 ms, mode auto, pipeline empty
module rgb_fade_brightness_renderer (
  input  logic          clk_i,
  input  logic          rst_ni,
  rfbr_item_if.sink     item_i,
  rfbr_result_if.source result_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import rfbr_pkg::*;

  logic        fade_on_q;
  logic [15:0] interval_q;
  logic [2:0]  mode_q;
  logic [31:0] last_step_q;
  logic        cfg_wr;

  logic        accept, is_render, is_force, has_result;
  logic [31:0] elapsed;
  logic        step_due;
  level_t      bright;
  level_t      bright_s1_q;
  logic        s1_valid_q, s2_valid_q;
  logic        s1_free, s2_free, out_free;
  lane_ctrl_t  ctrl;
  level_t [2:0] goal_in, lvl;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_on_q  <= FADE_ON_RST;
      interval_q <= INTERVAL_RST;
      mode_q     <= MODE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FADE_ON:  fade_on_q  <= pwdata[0];
        REG_INTERVAL: interval_q <= pwdata[15:0];
        REG_MODE:     mode_q     <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FADE_ON:  prdata = {31'd0, fade_on_q};
      REG_INTERVAL: prdata = {16'd0, interval_q};
      REG_MODE:     prdata = {29'd0, mode_q};
      default:      prdata = '0;
    endcase
  end

  // item decode and fade timing
  assign accept     = item_i.valid && item_i.ready;
  assign is_render  = item_i.cmd == CMD_RENDER;
  assign is_force   = item_i.cmd == CMD_FORCE;
  assign has_result = is_render || is_force;
  assign elapsed    = item_i.now_ms - last_step_q;
  assign step_due   = elapsed >= {16'd0, interval_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_step_q <= '0;
    end else if (ctrl.do_step) begin
      last_step_q <= item_i.now_ms;
    end
  end

  always_comb begin
    unique case (mode_q) inside
      MODE_DIST, MODE_HYBRID: bright = item_i.distance_brightness;
      MODE_AUTO, MODE_MANUAL: bright = item_i.ambient_brightness;
      default:                bright = FULL_LEVEL;
    endcase
  end

  // stage handshake, ready runs back from the output register
  assign s2_free      = !s2_valid_q || out_free;
  assign s1_free      = !s1_valid_q || s2_free;
  assign item_i.ready = s1_free;

  always_comb begin
    ctrl.load_goal = accept && (item_i.cmd == CMD_SET_GOAL);
    ctrl.do_step   = accept && is_render && fade_on_q && step_due;
    ctrl.do_jump   = accept && (is_force || (is_render && !fade_on_q));
    ctrl.ld_s1     = s1_free;
    ctrl.ld_s2     = s2_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_free) s1_valid_q <= accept && has_result;
      if (s2_free) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_free) bright_s1_q <= bright;
  end

  assign goal_in[0] = item_i.red_in;
  assign goal_in[1] = item_i.green_in;
  assign goal_in[2] = item_i.blue_in;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    rfbr_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .goal_i   (goal_in[g]),
      .bright_i (bright_s1_q),
      .pwm_o    (lvl[g])
    );
  end

  rfbr_merge u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s2_valid_i (s2_valid_q),
    .lvl_i      (lvl),
    .free_o     (out_free),
    .result_o   (result_o)
  );

endmodule
